>>> src/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg: shared types and constants for the substring match stream
// Pattern geometry, column limits, register indexes and the queue entry.
// ----------------------------------------------------------------------------
package ssm_pkg;

	localparam int unsigned MAX_PATTERN  = 16;
	localparam int unsigned MAX_COLUMNS  = 4096;
	localparam int unsigned PAT_SLOTS    = 16;
	localparam int unsigned PAT_LIMIT    = (MAX_PATTERN < PAT_SLOTS) ? MAX_PATTERN : PAT_SLOTS;
	localparam int unsigned CP_W         = 21;
	localparam int unsigned ROW_W        = 21;
	localparam int unsigned LEN_W        = 5;
	localparam int unsigned COL_W        = $clog2(MAX_COLUMNS + 1);
	localparam int unsigned OUT_COL_W    = 12;
	localparam int unsigned QUEUE_DEPTH  = 4;
	localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CP_W-1:0] CHAR_UPPER_A = CP_W'(65);
	localparam logic [CP_W-1:0] CHAR_UPPER_Z = CP_W'(90);
	localparam logic [CP_W-1:0] CASE_OFFSET  = CP_W'(32);

	localparam logic [1:0] CFG_PAT_LOW  = 2'd0;
	localparam logic [1:0] CFG_PAT_HIGH = 2'd1;
	localparam logic [1:0] CFG_PAT_LEN  = 2'd2;
	localparam logic [1:0] CFG_CASE     = 2'd3;

	typedef struct packed {
		logic [63:0] pat_low;
		logic [63:0] pat_high;
		logic        exact;
	} cmp_cfg_t;

	typedef struct packed {
		logic [PAT_SLOTS-1:0]   eq;
		logic signed [ROW_W-1:0] row;
		logic                   first;
	} cell_t;

	function automatic logic [CP_W-1:0] fold_case(input logic [CP_W-1:0] v);
		if (v >= CHAR_UPPER_A && v <= CHAR_UPPER_Z)
			return v + CASE_OFFSET;
		return v;
	endfunction

endpackage

>>> src/substring_match_stream.sv
// ----------------------------------------------------------------------------
// substring_match_stream: streaming substring search over text cells
// One cell per request in; one match request out for each pattern hit.
// ----------------------------------------------------------------------------
// Input channel: codepoint, row_index, first_in_row, taken when in_valid is
// high and in_stall is low. first_in_row restarts the column count at zero.
// Output channel: match_column (start column) and match_row, taken when
// out_valid is high and out_stall is low. Overlapping hits are all sent.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write only
// while no requests are in flight. cfg_ready is always high.
// Throughput: one cell per cycle while out_stall stays low, set by the
// shift-and update in the match engine; a stalled result holds the flow.
// Each cell passes through the queue, and a hit then sets the result register.
// A four-entry queue sits between classifier and engine; when the receiver
// stalls with a result pending, the queue fills and in_stall rises once it
// is full. Reset clears the queue, the match vector, the column count and
// the pattern registers; the exact-compare flag resets to one.
// ----------------------------------------------------------------------------
module substring_match_stream import ssm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CP_W-1:0]         codepoint,
	input  logic signed [ROW_W-1:0] row_index,
	input  logic                    first_in_row,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [OUT_COL_W-1:0]    match_column,
	output logic signed [ROW_W-1:0] match_row,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [63:0]             cfg_data
);

	logic [63:0]      pat_low_q;
	logic [63:0]      pat_high_q;
	logic [LEN_W-1:0] pat_len_q;
	logic             case_q;

	cmp_cfg_t cmp_cfg;
	cell_t    front_cell;
	cell_t    queue_cell;
	logic     q_full;
	logic     q_not_empty;
	logic     q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= '0;
			case_q     <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PAT_LOW:  pat_low_q  <= cfg_data;
				CFG_PAT_HIGH: pat_high_q <= cfg_data;
				CFG_PAT_LEN:  pat_len_q  <= cfg_data[LEN_W-1:0];
				CFG_CASE:     case_q     <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	assign cmp_cfg.pat_low  = pat_low_q;
	assign cmp_cfg.pat_high = pat_high_q;
	assign cmp_cfg.exact    = case_q;

	assign in_stall = q_full;

	ssm_front u_front (
		.cfg          (cmp_cfg),
		.codepoint    (codepoint),
		.row_index    (row_index),
		.first_in_row (first_in_row),
		.entry        (front_cell)
	);

	ssm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !q_full),
		.push_data (front_cell),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (queue_cell)
	);

	ssm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pat_len      (pat_len_q),
		.cell_valid   (q_not_empty),
		.entry        (queue_cell),
		.cell_pop     (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.match_column (match_column),
		.match_row    (match_row)
	);

endmodule

>>> src/ssm_front.sv
// ----------------------------------------------------------------------------
// ssm_front: cell classifier
// Compares the incoming codepoint against every pattern byte in parallel.
// ----------------------------------------------------------------------------
module ssm_front import ssm_pkg::*; (
	input  cmp_cfg_t                cfg,
	input  logic [CP_W-1:0]         codepoint,
	input  logic signed [ROW_W-1:0] row_index,
	input  logic                    first_in_row,
	output cell_t                   entry
);

	logic [CP_W-1:0]      a;
	logic [127:0]         pat_all;
	logic [PAT_SLOTS-1:0] eq;

	assign pat_all = {cfg.pat_high, cfg.pat_low};
	assign a = cfg.exact ? codepoint : fold_case(codepoint);

	always_comb begin
		logic [CP_W-1:0] b;
		for (int k = 0; k < PAT_SLOTS; k++) begin
			b = CP_W'(pat_all[8*k +: 8]);
			if (!cfg.exact)
				b = fold_case(b);
			eq[k] = (a == b);
		end
	end

	assign entry = {eq, row_index, first_in_row};

endmodule

>>> src/ssm_queue.sv
// ----------------------------------------------------------------------------
// ssm_queue: short queue of classified cells
// Decouples the classifier from the match engine.
// ----------------------------------------------------------------------------
module ssm_queue import ssm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  cell_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output cell_t pop_data
);

	cell_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> src/ssm_back.sv
// ----------------------------------------------------------------------------
// ssm_back: match engine
// Shift-and update, row column tracking and the result register.
// ----------------------------------------------------------------------------
module ssm_back import ssm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [LEN_W-1:0]        pat_len,
	input  logic                    cell_valid,
	input  cell_t                   entry,
	output logic                    cell_pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [OUT_COL_W-1:0]    match_column,
	output logic signed [ROW_W-1:0] match_row
);

	logic [PAT_SLOTS-1:0] vec_q;
	logic [COL_W-1:0]     col_q;
	logic                 out_valid_q;
	logic [OUT_COL_W-1:0] col_out_q;
	logic signed [ROW_W-1:0] row_out_q;

	logic [PAT_SLOTS-1:0] vec_eff;
	logic [COL_W-1:0]     col_eff;
	logic [PAT_SLOTS-1:0] len_mask;
	logic [PAT_SLOTS-1:0] vec_nxt;
	logic                 len_ok;
	logic                 col_full;
	logic                 hit;
	logic [COL_W-1:0]     match_start;

	assign cell_pop = cell_valid && (!out_valid_q || !out_stall);

	assign vec_eff  = entry.first ? '0 : vec_q;
	assign col_eff  = entry.first ? '0 : col_q;
	assign col_full = (col_eff >= COL_W'(MAX_COLUMNS));
	assign len_ok   = (pat_len != '0) && (pat_len <= LEN_W'(PAT_LIMIT));

	always_comb begin
		for (int k = 0; k < PAT_SLOTS; k++)
			len_mask[k] = (LEN_W'(k) < pat_len);
	end

	assign vec_nxt     = len_ok ? (((vec_eff << 1) | PAT_SLOTS'(1)) & entry.eq & len_mask) : '0;
	assign hit         = len_ok && !col_full && vec_nxt[4'(pat_len - 1'b1)];
	assign match_start = col_eff + COL_W'(1) - COL_W'(pat_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_q       <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cell_pop) begin
				if (col_full) begin
					vec_q <= '0;
					col_q <= COL_W'(MAX_COLUMNS);
				end else begin
					vec_q <= vec_nxt;
					col_q <= col_eff + 1'b1;
				end
				out_valid_q <= hit;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cell_pop && hit) begin
			col_out_q <= match_start[OUT_COL_W-1:0];
			row_out_q <= entry.row;
		end
	end

	assign out_valid    = out_valid_q;
	assign match_column = col_out_q;
	assign match_row    = row_out_q;

endmodule

>>> bench/tb_substring_match_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_substring_match_stream: self-checking bench for the substring matcher
// Streams text cells through the block and predicts each pattern hit with a
// shift-and model of its own. Directed rows cover overlaps, row restarts,
// case folding, wide codepoints, full and oversized lengths, a pattern change
// mid-row and a row past the column limit. Random rows follow, built mostly
// from whole or broken copies of the pattern, under changing stall patterns.
// ----------------------------------------------------------------------------
module tb_substring_match_stream;
	import ssm_pkg::*;

	localparam int SETTLE_CYCLES = 10;

	typedef struct {
		logic [OUT_COL_W-1:0]    column;
		logic signed [ROW_W-1:0] row;
	} hit_t;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    in_valid     = 1'b0;
	logic                    in_stall;
	logic [CP_W-1:0]         codepoint    = '0;
	logic signed [ROW_W-1:0] row_index    = '0;
	logic                    first_in_row = 1'b0;
	logic                    out_valid;
	logic                    out_stall    = 1'b0;
	logic [OUT_COL_W-1:0]    match_column;
	logic signed [ROW_W-1:0] match_row;
	logic                    cfg_valid    = 1'b0;
	logic                    cfg_ready;
	logic [1:0]              cfg_index    = '0;
	logic [63:0]             cfg_data     = '0;

	// matcher state and register copies
	logic [127:0]         pat_bytes = '0;
	logic [LEN_W-1:0]     pat_len   = '0;
	logic                 exact_cmp = 1'b1;
	logic [PAT_SLOTS-1:0] hit_vec   = '0;
	logic [COL_W-1:0]     col_pos   = '0;

	hit_t pending_hits[$];
	hit_t head_hit;
	int   errors         = 0;
	int   src_idle_pct   = 24;
	int   sink_stall_pct = 74;

	string symbols = "abABzZ@[";

	substring_match_stream DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.codepoint(codepoint), .row_index(row_index), .first_in_row(first_in_row),
		.out_valid(out_valid), .out_stall(out_stall),
		.match_column(match_column), .match_row(match_row),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_hits.size() == 0) begin
				errors++;
				$display("%0t: unexpected match, expected none, actual column %0d row %0d",
					$time, match_column, $signed(match_row));
			end else begin
				head_hit = pending_hits.pop_front();
				if (match_column !== head_hit.column) begin
					errors++;
					$display("%0t: match_column expected %0d actual %0d",
						$time, head_hit.column, match_column);
				end
				if (match_row !== head_hit.row) begin
					errors++;
					$display("%0t: match_row expected %0d actual %0d",
						$time, $signed(head_hit.row), $signed(match_row));
				end
			end
		end
	end

	initial begin
		#4_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [CP_W-1:0] to_lower(input logic [CP_W-1:0] v);
		if (v >= CHAR_UPPER_A && v <= CHAR_UPPER_Z)
			return v + CASE_OFFSET;
		return v;
	endfunction

	function automatic logic [CP_W-1:0] swap_case(input logic [CP_W-1:0] v);
		if ((v >= CHAR_UPPER_A && v <= CHAR_UPPER_Z) ||
		    (v >= CHAR_UPPER_A + CASE_OFFSET && v <= CHAR_UPPER_Z + CASE_OFFSET))
			return v ^ CASE_OFFSET;
		return v;
	endfunction

	function automatic logic [127:0] text_bytes(input string s);
		logic [127:0] v;
		int i;
		v = '0;
		for (i = 0; i < s.len() && i < 16; i++)
			v[8*i +: 8] = s[i];
		return v;
	endfunction

	function automatic logic [CP_W-1:0] pick_symbol();
		if ($urandom_range(0, 2) == 0)
			return CP_W'(pat_bytes[8*$urandom_range(0, 15) +: 8]);
		return CP_W'(symbols[$urandom_range(0, symbols.len() - 1)]);
	endfunction

	function automatic logic signed [ROW_W-1:0] random_row();
		if ($urandom_range(0, 1) == 0)
			return ROW_W'($urandom_range(0, 4095));
		return ROW_W'(-int'($urandom_range(1, 1048576)));
	endfunction

	task automatic predict_match(input logic [CP_W-1:0] cp, input logic signed [ROW_W-1:0] row,
			input bit first);
		logic [PAT_SLOTS-1:0] eq;
		logic [CP_W-1:0]      a;
		logic [CP_W-1:0]      b;
		logic [COL_W-1:0]     col;
		hit_t                 h;
		int                   k;
		if (first) begin
			hit_vec = '0;
			col_pos = '0;
		end
		if (col_pos >= MAX_COLUMNS) begin
			hit_vec = '0;
			col_pos = COL_W'(MAX_COLUMNS);
			return;
		end
		col     = col_pos;
		col_pos = col_pos + 1'b1;
		if (pat_len == 0 || pat_len > PAT_LIMIT) begin
			hit_vec = '0;
			return;
		end
		eq = '0;
		for (k = 0; k < pat_len; k++) begin
			a = cp;
			b = CP_W'(pat_bytes[8*k +: 8]);
			if (!exact_cmp) begin
				a = to_lower(a);
				b = to_lower(b);
			end
			eq[k] = (a == b);
		end
		hit_vec = ((hit_vec << 1) | PAT_SLOTS'(1)) & eq;
		if (hit_vec[pat_len - 1]) begin
			h.column = OUT_COL_W'(col + 1'b1 - pat_len);
			h.row    = row;
			pending_hits.push_back(h);
		end
	endtask

	task automatic send_cell(input logic [CP_W-1:0] cp, input logic signed [ROW_W-1:0] row,
			input bit first);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		codepoint    <= cp;
		row_index    <= row;
		first_in_row <= first;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_match(cp, row, first);
	endtask

	task automatic send_text(input string s, input logic signed [ROW_W-1:0] row, input bit first);
		int i;
		for (i = 0; i < s.len(); i++)
			send_cell(CP_W'(s[i]), row, first && i == 0);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_PAT_LOW:  pat_bytes[63:0]   = data;
			CFG_PAT_HIGH: pat_bytes[127:64] = data;
			CFG_PAT_LEN:  pat_len           = data[LEN_W-1:0];
			CFG_CASE:     exact_cmp         = data[0];
		endcase
	endtask

	task automatic configure(input logic [127:0] bytes, input int len, input bit exact);
		settle();
		write_reg(CFG_PAT_LOW, bytes[63:0]);
		write_reg(CFG_PAT_HIGH, bytes[127:64]);
		write_reg(CFG_PAT_LEN, 64'(len));
		write_reg(CFG_CASE, 64'(exact));
		cfg_valid <= 1'b0;
	endtask

	task automatic test_length_zero();
		send_cell('0, '0, 1'b1);
		send_cell('0, '0, 1'b0);
		send_cell('0, '0, 1'b0);
	endtask

	task automatic test_overlap();
		configure(text_bytes("aba"), 3, 1'b1);
		send_text("ababa", ROW_W'(-1048576), 1'b1);
	endtask

	task automatic test_new_row();
		send_text("ab", 21'sd6, 1'b1);
		send_text("aba", 21'sd7, 1'b1);
	endtask

	task automatic test_case_fold();
		configure(text_bytes("AzZ["), 4, 1'b0);
		send_text("aZz[", 21'sd3, 1'b1);
		send_text("aZz{", 21'sd3, 1'b1);
		configure(text_bytes("AzZ["), 4, 1'b1);
		send_text("azZ[AzZ[", 21'sd4, 1'b1);
	endtask

	task automatic test_wide_codepoint();
		configure(128'h00FF, 2, 1'b0);
		send_cell(CP_W'(21'h1000FF), 21'sd4095, 1'b1);
		send_cell(CP_W'(21'h100000), 21'sd4095, 1'b0);
		send_cell(CP_W'(21'h0000FF), 21'sd4095, 1'b0);
		send_cell(CP_W'(21'h000000), 21'sd4095, 1'b0);
		send_cell(CP_W'(21'h1FFFFF), 21'sd4095, 1'b0);
	endtask

	task automatic test_full_length();
		configure(text_bytes("0123456789abcdef"), 16, 1'b1);
		send_text("x0123456789abcdef", -21'sd1, 1'b1);
		configure(text_bytes("0123456789abcdef"), 17, 1'b1);
		send_text("0123456789abcdef", -21'sd1, 1'b1);
		configure(text_bytes("0123456789abcdef"), 31, 1'b1);
		send_text("0123456789abcdef", -21'sd1, 1'b1);
		configure(text_bytes("0123456789abcdef"), 16, 1'b0);
		send_text("0123456789ABCDEF", -21'sd2, 1'b1);
	endtask

	task automatic test_config_mid_row();
		configure(text_bytes("ab"), 2, 1'b1);
		send_text("a", 21'sd9, 1'b1);
		configure(text_bytes("xb"), 2, 1'b1);
		send_text("b", 21'sd9, 1'b0);
		configure(text_bytes("b"), 1, 1'b1);
		send_text("b", 21'sd9, 1'b0);
	endtask

	task automatic test_long_row();
		int c;
		logic [CP_W-1:0] cp;
		configure(text_bytes("xy"), 2, 1'b1);
		for (c = 0; c < MAX_COLUMNS + 2; c++) begin
			if (c == 100 || c == MAX_COLUMNS - 2 || c == MAX_COLUMNS)
				cp = CP_W'("x");
			else if (c == 101 || c == MAX_COLUMNS - 1 || c == MAX_COLUMNS + 1)
				cp = CP_W'("y");
			else
				cp = CP_W'("q");
			send_cell(cp, 21'sd12, c == 0);
		end
		send_text("xy", 21'sd13, 1'b1);
	endtask

	task automatic random_config();
		logic [127:0] bytes;
		int i, r, len;
		for (i = 0; i < 16; i++)
			bytes[8*i +: 8] = symbols[$urandom_range(0, symbols.len() - 1)];
		if ($urandom_range(0, 99) < 15)
			bytes = {$urandom, $urandom, $urandom, $urandom};
		r = $urandom_range(0, 99);
		if (r < 6)
			len = 0;
		else if (r < 12)
			len = 16;
		else if (r < 16)
			len = $urandom_range(17, 31);
		else if (r < 80)
			len = $urandom_range(1, 4);
		else
			len = $urandom_range(5, 15);
		configure(bytes, len, 1'($urandom_range(0, 1)));
	endtask

	task automatic test_random_text(input int n_cells, input int src_pct, input int sink_pct);
		logic [CP_W-1:0]         cells[$];
		logic [CP_W-1:0]         b;
		logic signed [ROW_W-1:0] row;
		int sent, row_len, n, cut, i, r;
		bit first;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		sent = 0;
		while (sent < n_cells) begin
			if (sent == 0 || $urandom_range(0, 99) < 10)
				random_config();
			row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 24);
			n = (pat_len == 0 || pat_len > PAT_LIMIT) ? $urandom_range(1, 4) : int'(pat_len);
			cells.delete();
			while (cells.size() < row_len) begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					// whole pattern, or a broken prefix of it
					cut = (r < 40) ? n : $urandom_range(1, n);
					for (i = 0; i < cut; i++) begin
						b = CP_W'(pat_bytes[8*i +: 8]);
						if ($urandom_range(0, 99) < (exact_cmp ? 3 : 30))
							b = swap_case(b);
						cells.push_back(b);
					end
				end else if (r < 95) begin
					cells.push_back(pick_symbol());
				end else begin
					cells.push_back(CP_W'($urandom_range(0, (1 << CP_W) - 1)));
				end
			end
			row   = random_row();
			first = ($urandom_range(0, 9) != 0);
			for (i = 0; i < cells.size(); i++)
				send_cell(cells[i], row, first && i == 0);
			sent += cells.size();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_length_zero();
		test_overlap();
		test_new_row();
		test_case_fold();
		test_wide_codepoint();
		test_full_length();
		test_config_mid_row();
		test_long_row();
		test_random_text(520, 24, 74);
		test_random_text(520, 74, 24);
		test_random_text(520, 0, 0);

		settle();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
